>>> rtl/ccwang_pkg.sv
// ----------------------------------------------------------------------------
// ccwang_pkg - shared types and constants for the ccw angle block
// item formats, pipeline buses, fixed angle codes and the cordic atan table
// ----------------------------------------------------------------------------
package ccwang_pkg;

  // coordinate and product widths
  localparam int COORD_WIDTH       = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int PROD_W            = 2 * COORD_WIDTH;
  localparam int SUM_W             = PROD_W + 1;
  localparam int MAG_W             = PROD_W;

  // normalized magnitude lies in [2^29, 2^30)
  localparam int NORM_W     = 30;
  localparam int JUST_W     = (MAG_W > NORM_W) ? MAG_W : NORM_W;
  localparam int NORM_STEPS = $clog2(JUST_W);

  // cordic datapath
  localparam int CW       = NORM_W + 4;
  localparam int ZW       = 33;
  localparam int ACC_FRAC = 16;
  localparam int TAB_LEN  = 24;

  // result angle in 1/128 degree
  localparam int ANGLE_W = 16;
  localparam logic [ANGLE_W-1:0] ANG_ZERO    = 16'd0;
  localparam logic [ANGLE_W-1:0] ANG_QUARTER = 16'd11520;
  localparam logic [ANGLE_W-1:0] ANG_HALF    = 16'd23040;
  localparam logic [ANGLE_W-1:0] ANG_THREE_Q = 16'd34560;
  localparam logic [ANGLE_W-1:0] ANG_FULL    = 16'd46080;

  // accumulator constants, units of 2^-23 degree
  localparam logic signed [ZW-1:0] Z_QUARTER_TURN = 33'sd754974720;
  localparam logic signed [ZW-1:0] FULL_TURN_Z    = 33'sd3019898880;
  localparam logic signed [ZW-1:0] ROUND_Z        = 33'sd32768;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ref_x;
    logic signed [COORD_WIDTH-1:0] ref_y;
    logic signed [COORD_WIDTH-1:0] tgt_x;
    logic signed [COORD_WIDTH-1:0] tgt_y;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_deg;
    logic               zero_vector;
  } out_item_t;

  // result decided early, bypasses the cordic
  typedef struct packed {
    logic               forced;
    logic               zero_vector;
    logic [ANGLE_W-1:0] angle;
  } side_t;

  typedef struct packed {
    logic              valid;
    logic              c_neg;
    logic              d_neg;
    logic [JUST_W-1:0] c_mag;
    logic [JUST_W-1:0] d_mag;
    side_t             side;
  } norm_t;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    side_t                side;
  } rot_t;

  // atan(2^-i) in units of 2^-23 degree, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_z(input int idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:       val = 33'sd377487360;
      1:       val = 33'sd222843801;
      2:       val = 33'sd117744544;
      3:       val = 33'sd59768969;
      4:       val = 33'sd30000467;
      5:       val = 33'sd15014858;
      6:       val = 33'sd7509261;
      7:       val = 33'sd3754860;
      8:       val = 33'sd1877459;
      9:       val = 33'sd938733;
      10:      val = 33'sd469367;
      11:      val = 33'sd234683;
      12:      val = 33'sd117342;
      13:      val = 33'sd58671;
      14:      val = 33'sd29335;
      15:      val = 33'sd14668;
      16:      val = 33'sd7334;
      17:      val = 33'sd3667;
      18:      val = 33'sd1833;
      19:      val = 33'sd917;
      20:      val = 33'sd458;
      21:      val = 33'sd229;
      22:      val = 33'sd115;
      23:      val = 33'sd57;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/ccw_angle_between_vectors.sv
// ----------------------------------------------------------------------------
// ccw_angle_between_vectors - counterclockwise angle from u to v
// atan2(cross, dot) through a row of normalize and cordic cells, 1/128 degree
// ----------------------------------------------------------------------------
//
//   channel   handshake           payload      direction
//   in_       in_valid/in_stall   in_item_t    vector pair u, v
//   out_      out_valid/out_stall out_item_t   angle_deg, zero_vector
//
// one item enters per cycle while in_stall is low; each item passes the front,
// the normalize cells, the pre-rotation register, the cordic cells and the output register
// reset is synchronous and active low; it clears every valid bit in the row
// and both output registers, payload registers are not reset
// when out_stall holds a result, the next one parks in the skid register;
// in_stall then rises and the whole row freezes until the skid drains
//
module ccw_angle_between_vectors #(
  parameter int CORDIC_STAGES = ccwang_pkg::CORDIC_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ccwang_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ccwang_pkg::out_item_t out_item
);
  import ccwang_pkg::*;

  // only the tabled stages exist
  localparam int STAGES_USED = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;

  logic en;

  norm_t norm_bus [0:NORM_STEPS];
  rot_t  rot_bus  [0:STAGES_USED];

  // pre-rotation signals
  logic [NORM_W-1:0]    cm;
  logic [NORM_W-1:0]    dm;
  logic signed [CW-1:0] cm_s;
  logic signed [CW-1:0] dm_s;
  logic                 c_neg_eff;
  logic                 d_neg_eff;
  rot_t                 pre_r;
  rot_t                 pre_nxt;

  // finishing signals
  rot_t                 last;
  logic signed [ZW-1:0] z_wrap;
  logic [ANGLE_W-1:0]   res;
  out_item_t            last_item;

  // output register and skid
  logic      take;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      skid_valid_r;
  logic      skid_valid_nxt;
  out_item_t skid_item_r;
  out_item_t skid_item_nxt;

  // the row moves whenever the skid register is free
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  ccwang_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_item  (in_item),
    .norm_o   (norm_bus[0])
  );

  // common shift so the larger magnitude lands in the top bit
  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    ccwang_norm_cell #(
      .SHIFT (2 ** (NORM_STEPS - 1 - k))
    ) u_norm (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .cell_i (norm_bus[k]),
      .cell_o (norm_bus[k+1])
    );
  end

  // take the top bits, truncating; fold the left half plane onto the right
  always_comb begin
    cm   = norm_bus[NORM_STEPS].c_mag[JUST_W-1 -: NORM_W];
    dm   = norm_bus[NORM_STEPS].d_mag[JUST_W-1 -: NORM_W];
    cm_s = $signed(CW'(cm));
    dm_s = $signed(CW'(dm));
    // a magnitude truncated to zero counts as non-negative
    c_neg_eff = norm_bus[NORM_STEPS].c_neg && (cm != '0);
    d_neg_eff = norm_bus[NORM_STEPS].d_neg && (dm != '0);
    pre_nxt.valid = norm_bus[NORM_STEPS].valid;
    pre_nxt.side  = norm_bus[NORM_STEPS].side;
    if (!d_neg_eff) begin
      pre_nxt.x = dm_s;
      pre_nxt.y = c_neg_eff ? -cm_s : cm_s;
      pre_nxt.z = '0;
    end else if (!c_neg_eff) begin
      // rotate by -90 degrees, start at +90
      pre_nxt.x = cm_s;
      pre_nxt.y = dm_s;
      pre_nxt.z = Z_QUARTER_TURN;
    end else begin
      // rotate by +90 degrees, start at -90
      pre_nxt.x = cm_s;
      pre_nxt.y = -dm_s;
      pre_nxt.z = -Z_QUARTER_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r.valid <= 1'b0;
    end else if (en) begin
      pre_r <= pre_nxt;
    end
  end

  assign rot_bus[0] = pre_r;

  for (genvar s = 0; s < STAGES_USED; s++) begin : g_cordic
    ccwang_cordic_cell #(
      .STAGE (s)
    ) u_cordic (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .cell_i (rot_bus[s]),
      .cell_o (rot_bus[s+1])
    );
  end

  // wrap negative angles, round to 1/128 degree, fold a full turn to zero
  always_comb begin
    last   = rot_bus[STAGES_USED];
    z_wrap = last.z + (last.z[ZW-1] ? FULL_TURN_Z : {ZW{1'b0}}) + ROUND_Z;
    res    = z_wrap[ACC_FRAC +: ANGLE_W];
    if (res >= ANG_FULL) begin
      res = res - ANG_FULL;
    end
    last_item.zero_vector = last.side.zero_vector;
    last_item.angle_deg   = last.side.forced ? last.side.angle : res;
  end

  // output register with one skid entry
  assign take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    skid_valid_nxt = skid_valid_r;
    skid_item_nxt  = skid_item_r;
    if (skid_valid_r) begin
      if (take) begin
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end
    end else begin
      if (take) begin
        out_valid_nxt = 1'b0;
      end
      if (last.valid) begin
        if (!out_valid_r || take) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = last_item;
        end else begin
          skid_valid_nxt = 1'b1;
          skid_item_nxt  = last_item;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // skid holds an item only behind a held output
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // skid fills only when the output was stalled
  a_skid_fill : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid register filled without an output stall");

  // zero-length input gives angle zero
  a_zero_angle : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.zero_vector) |-> (out_item_r.angle_deg == ANG_ZERO))
    else $error("zero vector item with nonzero angle");

  // angle stays below a full turn
  a_angle_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.angle_deg < ANG_FULL))
    else $error("angle out of range");

endmodule

>>> rtl/ccwang_front.sv
// ----------------------------------------------------------------------------
// ccwang_front - products, cross and dot, sign and magnitude
// three register stages: products, sums, magnitudes plus early results
// ----------------------------------------------------------------------------
module ccwang_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  ccwang_pkg::in_item_t in_item,
  output ccwang_pkg::norm_t    norm_o
);
  import ccwang_pkg::*;

  logic                    a_valid_r;
  logic                    a_zero_r;
  logic signed [PROD_W-1:0] a_uxvy_r;
  logic signed [PROD_W-1:0] a_uyvx_r;
  logic signed [PROD_W-1:0] a_uxvx_r;
  logic signed [PROD_W-1:0] a_uyvy_r;
  logic                    a_zero_nxt;

  logic                    b_valid_r;
  logic                    b_zero_r;
  logic signed [SUM_W-1:0] b_cross_r;
  logic signed [SUM_W-1:0] b_dot_r;

  logic signed [SUM_W-1:0] c_abs;
  logic signed [SUM_W-1:0] d_abs;
  norm_t                   norm_r;
  norm_t                   norm_nxt;

  assign a_zero_nxt = (in_item.ref_x == '0 && in_item.ref_y == '0) ||
                      (in_item.tgt_x == '0 && in_item.tgt_y == '0);

  // magnitude and early result selection
  always_comb begin
    c_abs = b_cross_r[SUM_W-1] ? -b_cross_r : b_cross_r;
    d_abs = b_dot_r[SUM_W-1] ? -b_dot_r : b_dot_r;
    norm_nxt.valid = b_valid_r;
    norm_nxt.c_neg = b_cross_r[SUM_W-1];
    norm_nxt.d_neg = b_dot_r[SUM_W-1];
    norm_nxt.c_mag = JUST_W'(c_abs[MAG_W-1:0]);
    norm_nxt.d_mag = JUST_W'(d_abs[MAG_W-1:0]);
    norm_nxt.side.forced      = 1'b1;
    norm_nxt.side.zero_vector = 1'b0;
    norm_nxt.side.angle       = ANG_ZERO;
    if (b_zero_r) begin
      norm_nxt.side.zero_vector = 1'b1;
    end else if (b_cross_r == '0) begin
      norm_nxt.side.angle = b_dot_r[SUM_W-1] ? ANG_HALF : ANG_ZERO;
    end else if (b_dot_r == '0) begin
      norm_nxt.side.angle = b_cross_r[SUM_W-1] ? ANG_THREE_Q : ANG_QUARTER;
    end else begin
      norm_nxt.side.forced = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r    <= 1'b0;
      b_valid_r    <= 1'b0;
      norm_r.valid <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      a_zero_r  <= a_zero_nxt;
      a_uxvy_r  <= in_item.ref_x * in_item.tgt_y;
      a_uyvx_r  <= in_item.ref_y * in_item.tgt_x;
      a_uxvx_r  <= in_item.ref_x * in_item.tgt_x;
      a_uyvy_r  <= in_item.ref_y * in_item.tgt_y;
      b_valid_r <= a_valid_r;
      b_zero_r  <= a_zero_r;
      b_cross_r <= SUM_W'(a_uxvy_r) - SUM_W'(a_uyvx_r);
      b_dot_r   <= SUM_W'(a_uxvx_r) + SUM_W'(a_uyvy_r);
      norm_r    <= norm_nxt;
    end
  end

  assign norm_o = norm_r;

endmodule

>>> rtl/ccwang_norm_cell.sv
// ----------------------------------------------------------------------------
// ccwang_norm_cell - one step of the common left-justify shift
// shifts both magnitudes by SHIFT when the top SHIFT bits of both are clear
// ----------------------------------------------------------------------------
module ccwang_norm_cell #(
  parameter int SHIFT = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ccwang_pkg::norm_t cell_i,
  output ccwang_pkg::norm_t cell_o
);
  import ccwang_pkg::*;

  logic [JUST_W-1:0] both_mag;
  norm_t             cell_r;
  norm_t             cell_nxt;

  always_comb begin
    both_mag = cell_i.c_mag | cell_i.d_mag;
    cell_nxt = cell_i;
    if ((both_mag >> (JUST_W - SHIFT)) == '0) begin
      cell_nxt.c_mag = cell_i.c_mag << SHIFT;
      cell_nxt.d_mag = cell_i.d_mag << SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

>>> rtl/ccwang_cordic_cell.sv
// ----------------------------------------------------------------------------
// ccwang_cordic_cell - one vectoring micro-rotation
// drives y toward zero and accumulates the matching atan step in z
// ----------------------------------------------------------------------------
module ccwang_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  ccwang_pkg::rot_t cell_i,
  output ccwang_pkg::rot_t cell_o
);
  import ccwang_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE_STEP = atan_z(STAGE);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  rot_t                 cell_r;
  rot_t                 cell_nxt;

  always_comb begin
    xs       = cell_i.x >>> STAGE;
    ys       = cell_i.y >>> STAGE;
    cell_nxt = cell_i;
    if (!cell_i.y[CW-1]) begin
      cell_nxt.x = cell_i.x + ys;
      cell_nxt.y = cell_i.y - xs;
      cell_nxt.z = cell_i.z + ANGLE_STEP;
    end else begin
      cell_nxt.x = cell_i.x - ys;
      cell_nxt.y = cell_i.y + xs;
      cell_nxt.z = cell_i.z - ANGLE_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule
